// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; pulled in with an include by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition implies another on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/ps2s2a_pkg.sv
// Shared types, scan code constants and key lookup tables for the PS/2 translator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ps2s2a_pkg;

    // Scan code set 2 codes with special handling
    localparam logic [7:0] CODE_BREAK  = 8'hF0;
    localparam logic [7:0] CODE_CAPS   = 8'h58;
    localparam logic [7:0] CODE_NUM    = 8'h77;
    localparam logic [7:0] CODE_LSHIFT = 8'h12;
    localparam logic [7:0] CODE_RSHIFT = 8'h59;
    localparam logic [7:0] CODE_BKSP   = 8'h66;

    // First keypad code that depends on num lock
    localparam logic [6:0] KEYPAD_FIRST = 7'h69;

    // Lower-case letter range and the distance to upper case
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF    = 8'd32;

    // Result kinds
    localparam logic KIND_ASCII = 1'b0;
    localparam logic KIND_RAW   = 1'b1;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Request handed from front to back, with the flags seen at accept time
    typedef struct packed {
        logic       is_bksp;
        logic [6:0] code;
        logic       shift;
        logic       caps;
        logic       num;
    } t_req;

    // Queue status seen by both sides
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

    // Unshifted character of each code below 0x80; zero marks an unmapped key
    localparam logic [7:0] KEY_ROM [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
        8'h00, 8'h00, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
        8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
        8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
        8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
        8'h00, 8'h00, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h00,
        8'h00, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h00,
        8'h00, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'h00,
        8'h00, 8'h00, 8'h27, 8'h00, 8'h5B, 8'h3D, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h0A, 8'h5D, 8'h00, 8'h5C, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
        8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
        8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'h00,
        8'h00, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00
    };

    // Shifted form of a non-letter character; zero when it has none
    function automatic logic [7:0] shift_form(input logic [7:0] ch);
        logic [7:0] res;
        case (ch)
            8'h27:   res = 8'h22;
            8'h2C:   res = 8'h3C;
            8'h2D:   res = 8'h5F;
            8'h2E:   res = 8'h3E;
            8'h2F:   res = 8'h3F;
            8'h30:   res = 8'h29;
            8'h31:   res = 8'h21;
            8'h32:   res = 8'h40;
            8'h33:   res = 8'h23;
            8'h34:   res = 8'h24;
            8'h35:   res = 8'h25;
            8'h36:   res = 8'h5E;
            8'h37:   res = 8'h26;
            8'h38:   res = 8'h2A;
            8'h39:   res = 8'h28;
            8'h3B:   res = 8'h3A;
            8'h3D:   res = 8'h2B;
            8'h5B:   res = 8'h7B;
            8'h5C:   res = 8'h7C;
            8'h5D:   res = 8'h7D;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    // Character for a key release; zero means nothing is emitted
    function automatic logic [7:0] translate(input t_req r);
        logic [7:0] ch;
        logic [7:0] res;
        ch  = KEY_ROM[r.code];
        res = ch;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            if (r.caps ^ r.shift) begin
                res = ch - CASE_DIFF;
            end
        end else if (r.shift) begin
            res = shift_form(ch);
        end
        if (r.code >= KEYPAD_FIRST && !r.num) begin
            res = 8'h00;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ps2s2a_if.sv
// Valid/ready channel interfaces: scan bytes in, translated keys out.
// No dependencies.
`default_nettype none

interface ps2s2a_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2s2a_key_if;
    logic       valid;
    logic       ready;
    logic       key_kind;
    logic [7:0] key_value;

    modport source (output valid, output key_kind, output key_value, input ready);
    modport sink   (input valid, input key_kind, input key_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ps2s2a_front.sv
// Front end: accepts scan bytes, tracks break/shift/lock flags, queues requests.
// Depends on ps2s2a_pkg and the scan channel interface.
`default_nettype none

module ps2s2a_front import ps2s2a_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ps2s2a_scan_if.sink  i_scan,
    input  t_q_stat      i_q_stat,
    output logic         o_push,
    output t_req         o_push_req
);

    logic r_break_pending, n_break_pending;
    logic r_shift_held,    n_shift_held;
    logic r_caps_lock_on,  n_caps_lock_on;
    logic r_num_lock_on,   n_num_lock_on;

    logic       w_accept;
    logic [7:0] w_byte;
    logic       w_is_lock;
    logic       w_is_shift;

    assign i_scan.ready = !i_q_stat.full;
    assign w_accept     = i_scan.valid && i_scan.ready;
    assign w_byte       = i_scan.scan_byte;
    assign w_is_lock    = (w_byte == CODE_CAPS) || (w_byte == CODE_NUM);
    assign w_is_shift   = (w_byte == CODE_LSHIFT) || (w_byte == CODE_RSHIFT);

    // Update flags for the accepted byte
    always_comb begin
        n_break_pending = r_break_pending;
        n_shift_held    = r_shift_held;
        n_caps_lock_on  = r_caps_lock_on;
        n_num_lock_on   = r_num_lock_on;
        if (w_accept) begin
            if (w_byte == CODE_BREAK) begin
                n_break_pending = 1'b1;
            end else begin
                n_break_pending = 1'b0;
                if (w_byte == CODE_CAPS && !r_break_pending) begin
                    n_caps_lock_on = !r_caps_lock_on;
                end
                if (w_byte == CODE_NUM && !r_break_pending) begin
                    n_num_lock_on = !r_num_lock_on;
                end
                if (w_is_shift) begin
                    n_shift_held = !r_break_pending;
                end
            end
        end
    end

    // Queue a request for backspace make or an ordinary key release
    always_comb begin
        o_push_req.is_bksp = (w_byte == CODE_BKSP);
        o_push_req.code    = w_byte[6:0];
        o_push_req.shift   = r_shift_held;
        o_push_req.caps    = r_caps_lock_on;
        o_push_req.num     = r_num_lock_on;
        o_push = 1'b0;
        if (w_accept) begin
            if (w_byte == CODE_BKSP) begin
                o_push = !r_break_pending;
            end else if (!w_byte[7] && !w_is_lock && !w_is_shift) begin
                o_push = r_break_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_pending <= 1'b0;
            r_shift_held    <= 1'b0;
            r_caps_lock_on  <= 1'b0;
            r_num_lock_on   <= 1'b0;
        end else begin
            r_break_pending <= n_break_pending;
            r_shift_held    <= n_shift_held;
            r_caps_lock_on  <= n_caps_lock_on;
            r_num_lock_on   <= n_num_lock_on;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ps2s2a_fifo.sv
// Short request queue between front end and back end.
// Depends on ps2s2a_pkg for the request and status types.
`default_nettype none

module ps2s2a_fifo import ps2s2a_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_push,
    input  t_req     i_push_req,
    input  wire      i_pop,
    output t_req     o_head,
    output t_q_stat  o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ps2s2a_back.sv
// Back end: looks up queued requests in the key ROMs and drives the output register.
// Depends on ps2s2a_pkg and the key channel interface.
`default_nettype none

module ps2s2a_back import ps2s2a_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  t_req          i_head,
    input  t_q_stat       i_q_stat,
    output logic          o_pop,
    ps2s2a_key_if.source  o_key
);

    logic       r_valid, n_valid;
    logic       r_kind;
    logic [7:0] r_value;

    logic [7:0] w_char;
    logic       w_emit;

    assign w_char = translate(i_head);
    assign w_emit = i_head.is_bksp || (w_char != 8'h00);

    // Take the head whenever the output register is free or being drained
    assign o_pop = i_q_stat.not_empty && (!r_valid || o_key.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = w_emit;
        end else if (o_key.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result; drop requests with no character
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_kind  <= i_head.is_bksp ? KIND_RAW : KIND_ASCII;
            r_value <= i_head.is_bksp ? CODE_BKSP : w_char;
        end
    end

    assign o_key.valid     = r_valid;
    assign o_key.key_kind  = r_kind;
    assign o_key.key_value = r_value;

endmodule

`default_nettype wire

// File: rtl/core/ps2s2a_if_top_note.sv
// Holds no logic of its own; the channel interfaces live in ps2s2a_if.sv.
// No dependencies.
`default_nettype none
`default_nettype wire

// File: rtl/core/ps2_scancode_to_ascii.sv
// PS/2 scan code set 2 to ASCII translator.
//
// Input channel i_scan takes one keyboard byte per request (valid/ready).
// Output channel o_key gives at most one result per request: key_kind 0 is an
// ASCII character emitted on key release, key_kind 1 is the raw backspace code
// 0x66 emitted on key press. Break prefixes, shift and lock keys, high bytes
// and keys without a character give no result.
//
// Throughput: one byte per cycle while the queue is not full. The front end
// updates the break, shift and lock flags in the cycle a byte is accepted and,
// if the byte makes a request, pushes it into a QUEUE_DEPTH-entry queue; the
// back end does the ROM lookup and loads the output register. A result passes
// the queue write, then the output register load, before it can be taken.
// When o_key stalls, the output register holds, the queue fills, and i_scan
// ready drops once the queue is full; no result is lost.
// Reset (i_rst_n low, synchronous) clears all flags, empties the queue and
// drops any pending result. No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module ps2_scancode_to_ascii import ps2s2a_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ps2s2a_scan_if.sink   i_scan,
    ps2s2a_key_if.source  o_key
);

    logic    w_push;
    t_req    w_push_req;
    logic    w_pop;
    t_req    w_head;
    t_q_stat w_q_stat;

    ps2s2a_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan     (i_scan),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_push_req (w_push_req)
    );

    ps2s2a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_req (w_push_req),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_q_stat)
    );

    ps2s2a_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_key    (o_key)
    );

    // Break prefix never queues a request
    `ASSERT_IMPL(a_break_no_push, i_clk, i_rst_n,
        i_scan.valid && i_scan.ready && i_scan.scan_byte == CODE_BREAK, !w_push,
        "break prefix queued a request")
    // Raw results only carry the backspace code
    `ASSERT_IMPL(a_raw_is_bksp, i_clk, i_rst_n,
        o_key.valid && o_key.key_kind == KIND_RAW, o_key.key_value == CODE_BKSP,
        "raw result is not backspace")
    // ASCII results are never the empty character
    `ASSERT_IMPL(a_ascii_nonzero, i_clk, i_rst_n,
        o_key.valid && o_key.key_kind == KIND_ASCII, o_key.key_value != 8'h00,
        "empty ASCII result emitted")
    // Full queue blocks input and never sees a push
    `ASSERT_CLKD(a_full_blocks, i_clk, i_rst_n,
        !w_q_stat.full || (!i_scan.ready && !w_push),
        "queue full but input still open")

endmodule

`default_nettype wire

// File: dv/ps2_scancode_to_ascii_tb.sv
// Testbench for ps2_scancode_to_ascii: scan bytes in, key results checked against a predictor.
// Depends on ps2s2a_pkg and the channel interfaces in ps2s2a_if.sv.
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_tb;
    import ps2s2a_pkg::*;

    localparam int RANDOM_BYTES = 700;
    localparam int CHUNK_BYTES  = 100;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 50;
    localparam logic [7:0] CODE_EXT = 8'hE0;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } t_key_result;

    // One directed request; typed rows carry their own expected result
    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        logic       fires;
        logic       kind;
        logic [7:0] value;
    } t_scan_row;

    localparam int N_DIRECTED = 26;
    localparam t_scan_row DIRECTED [N_DIRECTED] = '{
        '{8'h1C,       1'b1, 1'b0, KIND_ASCII, 8'h00},     // make of 'a'
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{8'h1C,       1'b1, 1'b1, KIND_ASCII, "a"},       // release of 'a'
        '{CODE_BKSP,   1'b1, 1'b1, KIND_RAW,   CODE_BKSP}, // backspace press
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{CODE_BKSP,   1'b1, 1'b0, KIND_ASCII, 8'h00},     // backspace release
        '{8'h00,       1'b1, 1'b0, KIND_ASCII, 8'h00},     // lowest byte, unmapped
        '{8'hFF,       1'b1, 1'b0, KIND_ASCII, 8'h00},     // highest byte
        '{CODE_EXT,    1'b1, 1'b0, KIND_ASCII, 8'h00},     // extended prefix
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{8'h69,       1'b1, 1'b0, KIND_ASCII, 8'h00},     // keypad, num lock off
        '{CODE_LSHIFT, 1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{8'h1E,       1'b0, 1'b0, KIND_ASCII, 8'h00},     // shifted '2'
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{8'h29,       1'b1, 1'b0, KIND_ASCII, 8'h00},     // shifted space has no form
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{CODE_RSHIFT, 1'b1, 1'b0, KIND_ASCII, 8'h00},     // shift release
        '{CODE_CAPS,   1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{CODE_CAPS,   1'b1, 1'b0, KIND_ASCII, 8'h00},     // lock release keeps state
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{8'h1C,       1'b0, 1'b0, KIND_ASCII, 8'h00},     // caps lock letter
        '{CODE_NUM,    1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{CODE_BREAK,  1'b1, 1'b0, KIND_ASCII, 8'h00},
        '{8'h7C,       1'b0, 1'b0, KIND_ASCII, 8'h00}      // keypad '*' with num lock
    };

    logic clk;
    logic rst_n;

    ps2s2a_scan_if scan_ch ();
    ps2s2a_key_if  key_ch ();

    ps2_scancode_to_ascii uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_scan  (scan_ch),
        .o_key   (key_ch)
    );

    // Predictor state
    logic brk_seen;
    logic shift_down;
    logic caps_on;
    logic num_on;

    t_key_result pending_keys [$];
    int          n_errors;
    int          n_sent;
    int          n_results;
    int          n_raw;
    int          n_caps_flips;
    int          n_num_flips;
    logic        idle_on;
    logic        hold_req;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Unshifted character of a code below 0x80; zero for unmapped keys
    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h15: ch = "q";    7'h16: ch = "1";    7'h1A: ch = "z";    7'h1B: ch = "s";
            7'h1C: ch = "a";    7'h1D: ch = "w";    7'h1E: ch = "2";    7'h21: ch = "c";
            7'h22: ch = "x";    7'h23: ch = "d";    7'h24: ch = "e";    7'h25: ch = "4";
            7'h26: ch = "3";    7'h29: ch = " ";    7'h2A: ch = "v";    7'h2B: ch = "f";
            7'h2C: ch = "t";    7'h2D: ch = "r";    7'h2E: ch = "5";    7'h31: ch = "n";
            7'h32: ch = "b";    7'h33: ch = "h";    7'h34: ch = "g";    7'h35: ch = "y";
            7'h36: ch = "6";    7'h3A: ch = "m";    7'h3B: ch = "j";    7'h3C: ch = "u";
            7'h3D: ch = "7";    7'h3E: ch = "8";    7'h41: ch = ",";    7'h42: ch = "k";
            7'h43: ch = "i";    7'h44: ch = "o";    7'h45: ch = "0";    7'h46: ch = "9";
            7'h49: ch = ".";    7'h4A: ch = "/";    7'h4B: ch = "l";    7'h4C: ch = ";";
            7'h4D: ch = "p";    7'h4E: ch = "-";    7'h52: ch = "'";    7'h54: ch = "[";
            7'h55: ch = "=";    7'h5A: ch = 8'h0A;  7'h5B: ch = "]";    7'h5D: ch = "\\";
            7'h66: ch = 8'h08;  7'h69: ch = "1";    7'h6B: ch = "4";    7'h6C: ch = "7";
            7'h70: ch = "0";    7'h71: ch = ".";    7'h72: ch = "2";    7'h73: ch = "5";
            7'h74: ch = "6";    7'h75: ch = "8";    7'h76: ch = 8'h1B;  7'h79: ch = "+";
            7'h7A: ch = "3";    7'h7B: ch = "-";    7'h7C: ch = "*";    7'h7D: ch = "9";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted form of a non-letter character; zero when it has none
    function automatic logic [7:0] shifted_char(input logic [7:0] ch);
        logic [7:0] res;
        case (ch)
            "'": res = "\"";    ",": res = "<";     "-": res = "_";     ".": res = ">";
            "/": res = "?";     "0": res = ")";     "1": res = "!";     "2": res = "@";
            "3": res = "#";     "4": res = "$";     "5": res = "%";     "6": res = "^";
            "7": res = "&";     "8": res = "*";     "9": res = "(";     ";": res = ":";
            "=": res = "+";     "[": res = "{";     "\\": res = "|";    "]": res = "}";
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    // Character that a key release gives under the current flags; zero for none
    function automatic logic [7:0] released_char(input logic [6:0] code);
        logic [7:0] ch;
        ch = plain_char(code);
        if (ch == 8'h00) begin
            return 8'h00;
        end
        if (ch >= "a" && ch <= "z") begin
            if (caps_on ^ shift_down) begin
                ch = ch - 8'd32;
            end
        end else if (shift_down) begin
            ch = shifted_char(ch);
        end
        if (code >= KEYPAD_FIRST && !num_on) begin
            ch = 8'h00;
        end
        return ch;
    endfunction

    // Advance the flags by one scan byte; return 1 when a key result follows
    function automatic logic predict_key(input logic [7:0] code, output t_key_result res);
        logic       released;
        logic       fires;
        logic [7:0] ch;
        released = brk_seen;
        fires    = 1'b0;
        res      = '0;
        if (code == CODE_BREAK) begin
            brk_seen = 1'b1;
            return 1'b0;
        end
        if (code == CODE_CAPS) begin
            if (!released) begin
                caps_on = ~caps_on;
                n_caps_flips++;
            end
        end else if (code == CODE_NUM) begin
            if (!released) begin
                num_on = ~num_on;
                n_num_flips++;
            end
        end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            shift_down = ~released;
        end else if (code == CODE_BKSP) begin
            if (!released) begin
                fires     = 1'b1;
                res.kind  = KIND_RAW;
                res.value = CODE_BKSP;
            end
        end else if (!code[7]) begin
            ch = released_char(code[6:0]);
            if (released && ch != 8'h00) begin
                fires     = 1'b1;
                res.kind  = KIND_ASCII;
                res.value = ch;
            end
        end
        brk_seen = 1'b0;
        return fires;
    endfunction

    // Gap length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(6, 25);
        end
        return $urandom_range(1, 3);
    endfunction

    // Code below 0x80, mostly a mapped key
    function automatic logic [7:0] pick_key();
        logic [7:0] code;
        do begin
            code = 8'($urandom_range(0, 127));
        end while (plain_char(code[6:0]) == 8'h00 && $urandom_range(0, 4) != 0);
        return code;
    endfunction

    // Offer one request, wait for it to be taken, then queue its expected result
    task automatic send_scan(input logic [7:0] code, input logic typed,
                             input logic typed_fires, input t_key_result typed_res);
        t_key_result res;
        logic        fires;
        int          gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        repeat (gap) begin
            scan_ch.valid <= 1'b0;
            @(posedge clk);
        end
        scan_ch.valid     <= 1'b1;
        scan_ch.scan_byte <= code;
        do @(posedge clk); while (!scan_ch.ready);
        n_sent++;
        fires = predict_key(code, res);
        if (typed) begin
            fires = typed_fires;
            res   = typed_res;
        end
        if (fires) begin
            pending_keys.push_back(res);
        end
    endtask

    task automatic send_random(input logic [7:0] code);
        send_scan(code, 1'b0, 1'b0, '0);
    endtask

    // Drive ready: random stalls, a requested long hold-off, or always ready
    initial begin : key_drain
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                key_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = idle_len() - 1;
                key_ch.ready <= 1'b0;
            end else begin
                key_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted key result with the oldest expectation
    always @(posedge clk) begin : key_check
        t_key_result want;
        if (rst_n && key_ch.valid && key_ch.ready) begin
            n_results++;
            if (key_ch.key_kind == KIND_RAW) begin
                n_raw++;
            end
            if (pending_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value 0x%02h",
                                          key_ch.key_kind, key_ch.key_value));
            end else begin
                want = pending_keys.pop_front();
                if (key_ch.key_kind !== want.kind) begin
                    report_mismatch($sformatf("key_kind %0d, expected %0d",
                                              key_ch.key_kind, want.kind));
                end
                if (key_ch.key_value !== want.value) begin
                    report_mismatch($sformatf("key_value 0x%02h, expected 0x%02h",
                                              key_ch.key_value, want.value));
                end
            end
        end
    end

    // End the run when nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((scan_ch.valid && scan_ch.ready) || (key_ch.valid && key_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout after %0d cycles with no request accepted", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int         pick;
        int         chunk;
        logic       hold_done;
        logic [7:0] code;
        scan_ch.valid     = 1'b0;
        scan_ch.scan_byte = 8'h00;
        key_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        brk_seen          = 1'b0;
        shift_down        = 1'b0;
        caps_on           = 1'b0;
        num_on            = 1'b0;
        n_errors          = 0;
        n_sent            = 0;
        n_results         = 0;
        n_raw             = 0;
        n_caps_flips      = 0;
        n_num_flips       = 0;
        idle_on           = 1'b1;
        hold_req          = 1'b0;
        hold_done         = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_scan(DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].fires,
                      '{kind: DIRECTED[i].kind, value: DIRECTED[i].value});
        end

        // Random key sequences with some noise; every third chunk runs without gaps
        while (n_sent < N_DIRECTED + RANDOM_BYTES) begin
            chunk   = (n_sent - N_DIRECTED) / CHUNK_BYTES;
            idle_on = (chunk % 3 != 2);
            if (chunk == 2 && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                code = pick_key();
                send_random(code);
                send_random(CODE_BREAK);
                send_random(code);
            end else if (pick < 65) begin
                send_random($urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT);
            end else if (pick < 72) begin
                send_random(CODE_BREAK);
                send_random($urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT);
            end else if (pick < 80) begin
                code = $urandom_range(0, 1) ? CODE_CAPS : CODE_NUM;
                send_random(code);
                if ($urandom_range(0, 1)) begin
                    send_random(CODE_BREAK);
                    send_random(code);
                end
            end else if (pick < 86) begin
                send_random(CODE_BKSP);
                send_random(CODE_BREAK);
                send_random(CODE_BKSP);
            end else if (pick < 92) begin
                send_random(CODE_BREAK);
                send_random(8'($urandom_range(0, 255)));
            end else begin
                send_random(8'($urandom_range(0, 255)));
            end
        end
        scan_ch.valid <= 1'b0;
        idle_on = 1'b0;

        // Drain the remaining results, then watch for strays
        while (pending_keys.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d scan bytes (%0d directed); checked %0d key results, %0d raw",
                 n_sent, N_DIRECTED, n_results, n_raw);
        $display("Caps lock toggled %0d times, num lock %0d times; one %0d-cycle output hold",
                 n_caps_flips, n_num_flips, HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
